// File: design/bc_pkg.sv
package bc_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ORDER   = 3'd4;

  // First-order constants.
  localparam logic signed [17:0] DT_OFFSET = 18'sd20224;
  localparam logic signed [16:0] D1_OFFSET = 17'sd7168;
  localparam logic [6:0]         C6_TEMP_BIAS = 7'd50;
  localparam logic signed [10:0] C4_BIAS   = 11'sd512;
  localparam logic signed [13:0] TEMP_BASE = 14'sd200;
  localparam logic signed [17:0] SENS_BASE = 18'sd24576;
  localparam logic signed [19:0] PRES_BASE = 20'sd2500;

  // Second-order constants.
  localparam logic signed [13:0] TEMP_LOW_KNEE  = 14'sd200;
  localparam logic signed [13:0] TEMP_HIGH_KNEE = 14'sd450;
  localparam logic [6:0]         C6_CORR_BIAS   = 7'd24;
  localparam logic signed [20:0] PRES_LOW_REF   = 21'sd3500;
  localparam logic signed [20:0] PRES_HIGH_REF  = 21'sd10000;

  // Output clamp limits.
  localparam logic signed [16:0] TEMP_SAT_MIN = -17'sd2048;
  localparam logic signed [16:0] TEMP_SAT_MAX = 17'sd2047;
  localparam logic signed [23:0] PRES_SAT_MAX = 24'sd131071;

  // Calibration coefficients unpacked from the four factory words.
  typedef struct packed {
    logic [14:0] c1;
    logic [11:0] c2;
    logic [9:0]  c3;
    logic [9:0]  c4;
    logic [10:0] c5;
    logic [5:0]  c6;
    logic        so_en;
  } coef_t;

  // First-order results handed to the correction pipeline.
  typedef struct packed {
    logic signed [13:0] temp;
    logic signed [19:0] pres;
  } first_res_t;

endpackage

// File: design/barometer_compensation.sv
// Channel     Dir  Fields (from bit 0 up)
// s_*         in   tdata: pressure_raw[15:0], temperature_raw[31:16]
// m_*         out  tdata: temperature_out[11:0], pressure_out[28:12], zero[31:29]
//                  tuser: saturated_flag[0]
// cfg_*       in   cfg_index selects register 0..4, cfg_data[15:0] is the value
//
// One reading pair can enter every cycle unless the output stalls; each result
// passes through the twelve register stages of the two arithmetic pipelines.
// Reset (rst, synchronous) clears all stage valid bits and the calibration registers.
// Every stage holds while its successor is full and stalled, so a stall on the
// output only stops the stages behind a full one; empty stages keep filling.
module barometer_compensation import bc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // pressure_raw, temperature_raw
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // temperature_out, pressure_out, zero pad
  output logic [0:0]            m_tuser,   // saturated_flag
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  coef_t              coef;
  first_res_t         first;
  logic               first_valid;
  logic               first_ready;
  logic signed [11:0] temperature_out;
  logic [16:0]        pressure_out;
  logic               saturated_flag;

  // Calibration registers and coefficient unpacking.
  bc_cal_regs u_cal_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // First-order temperature and pressure.
  bc_first_order u_first_order (
    .clk             (clk),
    .rst             (rst),
    .coef            (coef),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .pressure_raw    (s_tdata[15:0]),
    .temperature_raw (s_tdata[31:16]),
    .out_valid       (first_valid),
    .out_ready       (first_ready),
    .res             (first)
  );

  // Second-order correction, clamping and output register.
  bc_second_order u_second_order (
    .clk             (clk),
    .rst             (rst),
    .coef            (coef),
    .in_valid        (first_valid),
    .in_ready        (first_ready),
    .first           (first),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .temperature_out (temperature_out),
    .pressure_out    (pressure_out),
    .saturated_flag  (saturated_flag)
  );

  assign m_tdata = {3'b000, pressure_out, temperature_out};
  assign m_tuser = saturated_flag;

endmodule

// File: design/bc_cal_regs.sv
module bc_cal_regs import bc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output coef_t                 coef
);

  logic [15:0] w1;
  logic [15:0] w2;
  logic [15:0] w3;
  logic [15:0] w4;
  logic        so_en;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      w1    <= '0;
      w2    <= '0;
      w3    <= '0;
      w4    <= '0;
      so_en <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAL_WORD_ONE:   w1    <= cfg_data;
        REG_CAL_WORD_TWO:   w2    <= cfg_data;
        REG_CAL_WORD_THREE: w3    <= cfg_data;
        REG_CAL_WORD_FOUR:  w4    <= cfg_data;
        REG_SECOND_ORDER:   so_en <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Bit-field unpacking of the factory words into C1..C6.
  always_comb begin
    coef.c1    = w1[15:1];
    coef.c2    = {w3[5:0], w4[5:0]};
    coef.c3    = w4[15:6];
    coef.c4    = w3[15:6];
    coef.c5    = {w1[0], w2[15:6]};
    coef.c6    = w2[5:0];
    coef.so_en = so_en;
  end

endmodule

// File: design/bc_first_order.sv
module bc_first_order import bc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  coef_t       coef,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] pressure_raw,
  input  logic [15:0] temperature_raw,
  output logic        out_valid,
  input  logic        out_ready,
  output first_res_t  res
);

  // Stage valid bits and advance enables, A (first) to F (last).
  logic va, vb, vc, vd, ve, vf;
  logic en_a, en_b, en_c, en_d, en_e, en_f;

  // A stage moves when it is empty or its successor moves.
  assign en_f     = !vf || out_ready;
  assign en_e     = !ve || en_f;
  assign en_d     = !vd || en_e;
  assign en_c     = !vc || en_d;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) vd <= vc;
      if (en_e) ve <= vd;
      if (en_f) vf <= ve;
    end
  end

  // Stage A: temperature difference and pressure offset.
  logic signed [17:0] dt_next;
  logic signed [16:0] d1m_next;
  logic signed [17:0] dt_a;
  logic signed [16:0] d1m_a;

  assign dt_next  = $signed({2'b00, temperature_raw})
                  - $signed({4'b0000, coef.c5, 3'b000}) - DT_OFFSET;
  assign d1m_next = $signed({1'b0, pressure_raw}) - D1_OFFSET;

  always_ff @(posedge clk) begin
    if (en_a) begin
      dt_a  <= dt_next;
      d1m_a <= d1m_next;
    end
  end

  // Stage B: the three products with dT.
  logic [6:0]         c6_t;
  logic signed [10:0] c4_m;
  logic signed [25:0] pt_next;
  logic signed [28:0] po_next;
  logic signed [28:0] ps_next;
  logic signed [25:0] pt_b;
  logic signed [28:0] po_b;
  logic signed [28:0] ps_b;
  logic signed [16:0] d1m_b;

  assign c6_t    = {1'b0, coef.c6} + C6_TEMP_BIAS;
  assign c4_m    = $signed({1'b0, coef.c4}) - C4_BIAS;
  assign pt_next = dt_a * $signed({1'b0, c6_t});
  assign po_next = dt_a * c4_m;
  assign ps_next = dt_a * $signed({1'b0, coef.c3});

  always_ff @(posedge clk) begin
    if (en_b) begin
      pt_b  <= pt_next;
      po_b  <= po_next;
      ps_b  <= ps_next;
      d1m_b <= d1m_a;
    end
  end

  // Stage C: first-order temperature, offset and sensitivity.
  logic signed [25:0] pt_sh;
  logic signed [28:0] po_sh;
  logic signed [28:0] ps_sh;
  logic signed [13:0] temp_next;
  logic signed [16:0] off_next;
  logic signed [17:0] sens_next;
  logic signed [13:0] temp_c;
  logic signed [16:0] off_c;
  logic signed [17:0] sens_c;
  logic signed [16:0] d1m_c;

  assign pt_sh     = pt_b >>> 10;
  assign po_sh     = po_b >>> 12;
  assign ps_sh     = ps_b >>> 10;
  assign temp_next = $signed(pt_sh[13:0]) + TEMP_BASE;
  assign off_next  = $signed({3'b000, coef.c2, 2'b00}) + $signed(po_sh[16:0]);
  assign sens_next = $signed({3'b000, coef.c1}) + $signed(ps_sh[17:0]) + SENS_BASE;

  always_ff @(posedge clk) begin
    if (en_c) begin
      temp_c <= temp_next;
      off_c  <= off_next;
      sens_c <= sens_next;
      d1m_c  <= d1m_b;
    end
  end

  // Stage D: sensitivity times pressure offset.
  logic signed [34:0] prod_next;
  logic signed [34:0] prod_d;
  logic signed [13:0] temp_d;
  logic signed [16:0] off_d;

  assign prod_next = sens_c * d1m_c;

  always_ff @(posedge clk) begin
    if (en_d) begin
      prod_d <= prod_next;
      temp_d <= temp_c;
      off_d  <= off_c;
    end
  end

  // Stage E: scaled product minus offset.
  logic signed [34:0] prod_sh;
  logic signed [20:0] x_next;
  logic signed [20:0] x_e;
  logic signed [13:0] temp_e;

  assign prod_sh = prod_d >>> 14;
  assign x_next  = $signed(prod_sh[20:0]) - off_d;

  always_ff @(posedge clk) begin
    if (en_e) begin
      x_e    <= x_next;
      temp_e <= temp_d;
    end
  end

  // Stage F: pressure = 10*X/32 + 2500, the times ten as two shifts.
  logic signed [24:0] x_w;
  logic signed [24:0] x10;
  logic signed [24:0] x10_sh;
  logic signed [19:0] pres_next;

  assign x_w       = x_e;
  assign x10       = (x_w <<< 3) + (x_w <<< 1);
  assign x10_sh    = x10 >>> 5;
  assign pres_next = $signed(x10_sh[19:0]) + PRES_BASE;

  always_ff @(posedge clk) begin
    if (en_f) begin
      res.temp <= temp_e;
      res.pres <= pres_next;
    end
  end

  assign out_valid = vf;

endmodule

// File: design/bc_second_order.sv
module bc_second_order import bc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  coef_t              coef,
  input  logic               in_valid,
  output logic               in_ready,
  input  first_res_t         first,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] temperature_out,
  output logic [16:0]        pressure_out,
  output logic               saturated_flag
);

  // Stage valid bits and advance enables, G (first) to L (output register).
  logic vg, vh, vi, vj, vk, vl;
  logic en_g, en_h, en_i, en_j, en_k, en_l;

  assign en_l     = !vl || out_ready;
  assign en_k     = !vk || en_l;
  assign en_j     = !vj || en_k;
  assign en_i     = !vi || en_j;
  assign en_h     = !vh || en_i;
  assign en_g     = !vg || en_h;
  assign in_ready = en_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
      vj <= 1'b0;
      vk <= 1'b0;
      vl <= 1'b0;
    end else begin
      if (en_g) vg <= in_valid;
      if (en_h) vh <= vg;
      if (en_i) vi <= vh;
      if (en_j) vj <= vi;
      if (en_k) vk <= vj;
      if (en_l) vl <= vk;
    end
  end

  // Stage G: pick the temperature region, its distance and its gain.
  // Outside both regions, or with the correction off, the gain is zero
  // so that both corrections come out as zero.
  logic               low_next;
  logic               high_next;
  logic signed [13:0] diff_lo;
  logic signed [13:0] diff_hi;
  logic [6:0]         c6_c;
  logic [9:0]         k_next;
  logic [12:0]        dd_next;
  logic               low_g;
  logic [9:0]         k_g;
  logic [12:0]        dd_g;
  logic signed [13:0] temp_g;
  logic signed [19:0] pres_g;

  assign low_next  = coef.so_en && (first.temp < TEMP_LOW_KNEE);
  assign high_next = coef.so_en && (first.temp > TEMP_HIGH_KNEE);
  assign diff_lo   = TEMP_LOW_KNEE - first.temp;
  assign diff_hi   = first.temp - TEMP_HIGH_KNEE;
  assign c6_c      = {1'b0, coef.c6} + C6_CORR_BIAS;

  always_comb begin
    priority if (low_next) begin
      dd_next = diff_lo[12:0];
      k_next  = {c6_c, 3'b000} + {2'b00, c6_c, 1'b0} + {3'b000, c6_c};
    end else if (high_next) begin
      dd_next = diff_hi[12:0];
      k_next  = {2'b00, c6_c, 1'b0} + {3'b000, c6_c};
    end else begin
      dd_next = '0;
      k_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_g) begin
      low_g  <= low_next;
      k_g    <= k_next;
      dd_g   <= dd_next;
      temp_g <= first.temp;
      pres_g <= first.pres;
    end
  end

  // Stage H: square of the temperature distance.
  logic [25:0]        dsq_h;
  logic               low_h;
  logic [9:0]         k_h;
  logic signed [13:0] temp_h;
  logic signed [19:0] pres_h;

  always_ff @(posedge clk) begin
    if (en_h) begin
      dsq_h  <= dd_g * dd_g;
      low_h  <= low_g;
      k_h    <= k_g;
      temp_h <= temp_g;
      pres_h <= pres_g;
    end
  end

  // Stage I: gain times squared distance.
  logic [35:0]        t2p_i;
  logic               low_i;
  logic signed [13:0] temp_i;
  logic signed [19:0] pres_i;

  always_ff @(posedge clk) begin
    if (en_i) begin
      t2p_i  <= k_h * dsq_h;
      low_i  <= low_h;
      temp_i <= temp_h;
      pres_i <= pres_h;
    end
  end

  // Stage J: T2, corrected temperature and the pressure-correction operands.
  logic [15:0]        t2;
  logic [17:0]        m_next;
  logic signed [20:0] pdiff_next;
  logic signed [16:0] temp_f_next;
  logic [17:0]        m_j;
  logic signed [20:0] pdiff_j;
  logic signed [16:0] temp_f_j;
  logic signed [19:0] pres_j;
  logic               low_j;

  assign t2          = t2p_i[35:20];
  assign m_next      = low_i ? ({1'b0, t2, 1'b0} + {2'b00, t2}) : {2'b00, t2};
  assign pdiff_next  = pres_i - (low_i ? PRES_LOW_REF : PRES_HIGH_REF);
  assign temp_f_next = temp_i - $signed({1'b0, t2});

  always_ff @(posedge clk) begin
    if (en_j) begin
      m_j      <= m_next;
      pdiff_j  <= pdiff_next;
      temp_f_j <= temp_f_next;
      pres_j   <= pres_i;
      low_j    <= low_i;
    end
  end

  // Stage K: P2 product before its shift.
  logic signed [39:0] p2p_k;
  logic signed [16:0] temp_f_k;
  logic signed [19:0] pres_k;
  logic               low_k;

  always_ff @(posedge clk) begin
    if (en_k) begin
      p2p_k    <= $signed({1'b0, m_j}) * pdiff_j;
      temp_f_k <= temp_f_j;
      pres_k   <= pres_j;
      low_k    <= low_j;
    end
  end

  // Stage L: final pressure, clamp both results, output register.
  logic signed [39:0] p2_sh;
  logic signed [23:0] pres_f;
  logic               t_lo;
  logic               t_hi;
  logic               p_lo;
  logic               p_hi;
  logic signed [11:0] temp_sat;
  logic [16:0]        pres_sat;

  assign p2_sh  = low_k ? (p2p_k >>> 14) : (p2p_k >>> 13);
  assign pres_f = pres_k - $signed(p2_sh[23:0]);
  assign t_lo   = temp_f_k < TEMP_SAT_MIN;
  assign t_hi   = temp_f_k > TEMP_SAT_MAX;
  assign p_lo   = pres_f < 24'sd0;
  assign p_hi   = pres_f > PRES_SAT_MAX;

  always_comb begin
    priority if (t_lo) begin
      temp_sat = TEMP_SAT_MIN[11:0];
    end else if (t_hi) begin
      temp_sat = TEMP_SAT_MAX[11:0];
    end else begin
      temp_sat = temp_f_k[11:0];
    end
    priority if (p_lo) begin
      pres_sat = '0;
    end else if (p_hi) begin
      pres_sat = PRES_SAT_MAX[16:0];
    end else begin
      pres_sat = pres_f[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_l) begin
      temperature_out <= temp_sat;
      pressure_out    <= pres_sat;
      saturated_flag  <= t_lo || t_hi || p_lo || p_hi;
    end
  end

  assign out_valid = vl;

endmodule

// File: design/bc_checker.sv
module bc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // A stalled result is held unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // With the output free to move, every stage can move, so input is taken.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input refused while output drains");

  // The flag is set only when a result sits at a clamp limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (m_tdata[11:0] == 12'h800) || (m_tdata[11:0] == 12'h7FF) ||
      (m_tdata[28:12] == 17'd0) || (m_tdata[28:12] == 17'h1FFFF))
    else $error("saturation flag without a clamped result");

endmodule

bind barometer_compensation bc_checker u_bc_checker (.*);
